// ===== design/delay_and_sum_beamformer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the delay-and-sum beamformer
// Shorthand for clocked implication checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DELAY_AND_SUM_BEAMFORMER_UNIT_DEFINES_SVH
`define DELAY_AND_SUM_BEAMFORMER_UNIT_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define DSB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante completes.
`define DSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dsb_pkg.sv =====
// ----------------------------------------------------------------------------
// dsb_pkg
// Shared constants and control structs of the delay-and-sum beamformer.
// ----------------------------------------------------------------------------
`default_nettype none

package dsb_pkg;

  // Fixed widths of the external fields.
  localparam int IN_W   = 16;  // microphone sample port width
  localparam int OUT_W  = 19;  // beam mean width, three fractional bits
  localparam int DLY_W  = 4;   // delay register width
  localparam int NREG   = 8;   // number of delay registers
  localparam int IDX_W  = 3;   // configuration index width

  // Control of one channel cell.
  typedef struct packed {
    logic             shift_en;   // a new frame is accepted this cycle
    logic             cfg_we;     // write this cell's delay register
    logic [DLY_W-1:0] cfg_delay;  // delay value to write
  } dsb_cell_ctl_t;

  // Pipeline control handed to the mean stage.
  typedef struct packed {
    logic advance;  // every stage moves one step this cycle
    logic valid;    // the stage feeding the mean unit holds a beat
  } dsb_pipe_ctl_t;

endpackage

`default_nettype wire

// ===== design/dsb_cell.sv =====
// ----------------------------------------------------------------------------
// dsb_cell
// One microphone channel: delay register, sample history line and the adder
// that folds the delayed sample into the partial sum passed along the row.
// ----------------------------------------------------------------------------
`default_nettype none

module dsb_cell #(
  parameter int DEPTH = 16,
  parameter int SB    = 16,
  parameter int SW    = 19
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dsb_pkg::dsb_cell_ctl_t ctl,
  input  logic [SB-1:0]          sample_in,
  input  logic signed [SW-1:0]   psum_in,
  output logic signed [SW-1:0]   psum_out
);
  import dsb_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int HD = DEPTH - 1;

  logic [DLY_W-1:0] delay_r;
  logic [SB-1:0]    hist_r [HD];
  logic [IW-1:0]    dsat;
  logic [IW-1:0]    tap_idx;
  logic [SB-1:0]    tap;

  // Slot zero holds the sample of one frame ago.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= '0;
      for (int j = 0; j < HD; j++) begin
        hist_r[j] <= '0;
      end
    end else begin
      if (ctl.cfg_we) begin
        delay_r <= ctl.cfg_delay;
      end
      if (ctl.shift_en) begin
        hist_r[0] <= sample_in;
        for (int j = 1; j < HD; j++) begin
          hist_r[j] <= hist_r[j-1];
        end
      end
    end
  end

  // A delay beyond the line length reads the oldest slot.
  always_comb begin
    if (32'(delay_r) > HD) begin
      dsat = IW'(HD);
    end else begin
      dsat = IW'(delay_r);
    end
  end

  assign tap_idx  = IW'(dsat - IW'(1));
  assign tap      = (dsat == '0) ? sample_in : hist_r[tap_idx];
  assign psum_out = psum_in + SW'($signed(tap));

endmodule

`default_nettype wire

// ===== design/dsb_mean_div.sv =====
// ----------------------------------------------------------------------------
// dsb_mean_div
// Floor of eight times the channel sum over the channel count, by a
// registered reciprocal multiply followed by a one-step remainder correction.
// ----------------------------------------------------------------------------
`default_nettype none

module dsb_mean_div #(
  parameter int CHANNELS = 8,
  parameter int SW       = 19
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dsb_pkg::dsb_pipe_ctl_t             ctl,
  input  logic signed [SW-1:0]               sum_in,
  output logic                               out_valid,
  output logic signed [dsb_pkg::OUT_W-1:0]   mean
);
  import dsb_pkg::*;

  // The sum is biased by a multiple of the channel count so the divide
  // works on a non-negative value; the bias is taken off at the end.
  localparam int XW = SW + 3;
  localparam int K  = XW;
  localparam int MW = XW + 3;
  localparam int EW = MW;
  localparam int PW = XW + MW;
  localparam int RW = XW + 7;
  localparam int FW = (EW + 1 > OUT_W) ? EW + 1 : OUT_W;

  localparam logic [MW:0]   SCALE = (MW + 1)'(1) << (K + 3);
  localparam logic [MW-1:0] MUL   = MW'(SCALE / CHANNELS);
  localparam logic [XW-1:0] OFFS  = XW'(CHANNELS) << (SW - 1);
  localparam logic [EW:0]   BIAS  = (EW + 1)'(1) << (SW + 2);

  logic                    v2_r, v3_r;
  logic [XW-1:0]           x_nxt, x_r;
  logic [PW-1:0]           prod_nxt, prod_r;
  logic [EW-1:0]           est;
  logic [RW-1:0]           rem;
  logic [EW-1:0]           q_corr;
  logic signed [EW:0]      qs;
  logic signed [FW-1:0]    qf;
  logic signed [OUT_W-1:0] mean_nxt, mean_r;

  assign x_nxt    = XW'(sum_in) + OFFS;
  assign prod_nxt = PW'(x_nxt) * PW'(MUL);

  // The estimate is low by at most one.
  assign est      = prod_r[PW-1:K];
  assign rem      = (RW'(x_r) << 3) - RW'(est) * RW'(CHANNELS);
  assign q_corr   = (rem >= RW'(CHANNELS)) ? EW'(est + EW'(1)) : est;
  assign qs       = $signed({1'b0, q_corr} - BIAS);
  assign qf       = FW'(qs);
  assign mean_nxt = qf[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (ctl.advance) begin
      v2_r <= ctl.valid;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      x_r    <= x_nxt;
      prod_r <= prod_nxt;
      mean_r <= mean_nxt;
    end
  end

  assign out_valid = v3_r;
  assign mean      = mean_r;

endmodule

`default_nettype wire

// ===== design/delay_and_sum_beamformer_unit.sv =====
// ----------------------------------------------------------------------------
// delay_and_sum_beamformer_unit
// Eight-microphone delay-and-sum beamformer with a continuous output stream.
//
// Each input beat carries one time-aligned sample per microphone on in_mic0
// to in_mic7 (in_valid / in_ready). Each output beat carries out_beam_mean,
// the mean of the delayed samples in signed fixed point with three
// fractional bits (out_valid / out_ready). Every input beat yields exactly
// one output beat, in order.
// Delays are written on the cfg_we / cfg_index / cfg_data port, one 4-bit
// register per microphone; the user must write them only while the block is
// idle, which the block itself does not enforce. A delay of zero uses the
// sample of the same beat; larger delays reach back that many beats.
// Throughput is one beat per cycle unless the output stalls. A beat passes
// three registers: the channel row's sum register, the mean unit's reciprocal
// multiply and the output register after its remainder correction.
// Synchronous reset clears all history lines to zero, the delays to zero and
// empties the pipeline; no clearing pass is needed afterwards. When the
// receiver holds out_ready low with a beat waiting, the whole pipeline
// freezes and in_ready drops, even while the earlier stages are empty.
// ----------------------------------------------------------------------------
`default_nettype none

module delay_and_sum_beamformer_unit #(
  parameter int CHANNELS    = 8,
  parameter int DELAY_DEPTH = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [dsb_pkg::IN_W-1:0]     in_mic0,
  input  logic signed [dsb_pkg::IN_W-1:0]     in_mic1,
  input  logic signed [dsb_pkg::IN_W-1:0]     in_mic2,
  input  logic signed [dsb_pkg::IN_W-1:0]     in_mic3,
  input  logic signed [dsb_pkg::IN_W-1:0]     in_mic4,
  input  logic signed [dsb_pkg::IN_W-1:0]     in_mic5,
  input  logic signed [dsb_pkg::IN_W-1:0]     in_mic6,
  input  logic signed [dsb_pkg::IN_W-1:0]     in_mic7,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dsb_pkg::OUT_W-1:0]    out_beam_mean,
  // Configuration port.
  input  logic                                cfg_we,
  input  logic [dsb_pkg::IDX_W-1:0]           cfg_index,
  input  logic [dsb_pkg::DLY_W-1:0]           cfg_data
);
  import dsb_pkg::*;

  // The sum grows by the log of the channel count over one sample.
  localparam int SW = SAMPLE_BITS + $clog2(CHANNELS);

  logic                 advance;
  logic                 accept;
  logic                 v1_r;
  logic signed [SW-1:0] sum_r;
  logic [IN_W-1:0]      mic_a [NREG];
  logic signed [SW-1:0] psum [CHANNELS + 1];
  dsb_cell_ctl_t        cell_ctl [CHANNELS];
  dsb_pipe_ctl_t        pipe_ctl;

  // All stages step together; they hold only while a finished beat waits
  // at the output and the receiver is not taking it.
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;

  assign mic_a[0] = in_mic0;
  assign mic_a[1] = in_mic1;
  assign mic_a[2] = in_mic2;
  assign mic_a[3] = in_mic3;
  assign mic_a[4] = in_mic4;
  assign mic_a[5] = in_mic5;
  assign mic_a[6] = in_mic6;
  assign mic_a[7] = in_mic7;

  // The row of channel cells: each adds its delayed sample to the partial
  // sum from its left neighbor. Samples are taken as raw bits and then
  // sign-extended from SAMPLE_BITS inside the cell.
  assign psum[0] = '0;

  for (genvar k = 0; k < CHANNELS; k++) begin : g_cell
    assign cell_ctl[k].shift_en  = accept;
    assign cell_ctl[k].cfg_we    = cfg_we && (cfg_index == IDX_W'(k));
    assign cell_ctl[k].cfg_delay = cfg_data;

    dsb_cell #(
      .DEPTH (DELAY_DEPTH),
      .SB    (SAMPLE_BITS),
      .SW    (SW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl[k]),
      .sample_in (SAMPLE_BITS'(mic_a[k])),
      .psum_in   (psum[k]),
      .psum_out  (psum[k+1])
    );
  end

  // First pipeline stage: the full channel sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sum_r <= psum[CHANNELS];
    end
  end

  assign pipe_ctl.advance = advance;
  assign pipe_ctl.valid   = v1_r;

  // Mean unit: reciprocal multiply and correction, then the output register.
  dsb_mean_div #(
    .CHANNELS (CHANNELS),
    .SW       (SW)
  ) u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (pipe_ctl),
    .sum_in    (sum_r),
    .out_valid (out_valid),
    .mean      (out_beam_mean)
  );

endmodule

`default_nettype wire

// ===== design/dsb_checker.sv =====
// ----------------------------------------------------------------------------
// dsb_checker
// Port-level checks of the beamformer's flow control and latency.
// ----------------------------------------------------------------------------
`default_nettype none
`include "delay_and_sum_beamformer_unit_defines.svh"

module dsb_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [dsb_pkg::OUT_W-1:0]         out_beam_mean
);

  // A stalled result beat stays put.
  `DSB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_beam_mean), "stalled output beat changed")

  // With no result waiting the block always takes input.
  `DSB_ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "input refused with empty output")

  // With the receiver taking beats, an accepted frame comes out on out_valid.
  `DSB_ASSERT_NEXT(a_latency, clk, rst_n, in_valid && in_ready ##1 out_ready ##1 out_ready, out_valid, "result missing three cycles after input")

endmodule

bind delay_and_sum_beamformer_unit dsb_checker u_dsb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_beam_mean (out_beam_mean)
);

`default_nettype wire
